[design/rpn_pkg.sv]
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

  localparam int MODE_W      = 3;
  localparam int NUM_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int DEPTH_W     = 7;
  localparam int OUT_TDATA_W = 40;

  localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOD  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd5;

  typedef struct packed {
    logic                latch_in;
    logic                push;
    logic                rd_second;
    logic                alu_load;
    logic                div_start;
    logic                div_take;
    logic                wb;
    logic                out_load;
    logic [MODE_W-1:0]   op;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic lt_two;
    logic full;
    logic tos_zero;
    logic div_done;
  } dp_stat_t;

endpackage

[design/rpn_div.sv]
module rpn_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [rpn_pkg::DATA_WIDTH-1:0] dividend,
  input  logic signed [rpn_pkg::DATA_WIDTH-1:0] divisor,
  output logic                                  done,
  output logic signed [rpn_pkg::DATA_WIDTH-1:0] remainder
);

  localparam int W = rpn_pkg::DATA_WIDTH;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [rpn_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]                   rem_r, rem_nxt;
  logic [W-1:0]                   quo_r, quo_nxt;
  logic [W-1:0]                   den_r, den_nxt;
  logic                           neg_r, neg_nxt;
  logic [W:0]                     shifted;
  logic [W:0]                     diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rpn_pkg::DIV_CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend[W-1] ? W'(-dividend) : W'(dividend);
      den_nxt  = divisor[W-1] ? W'(-divisor) : W'(divisor);
      neg_nxt  = dividend[W-1];
    end else if (busy_r) begin
      rem_nxt = diff[W] ? shifted[W-1:0] : diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rpn_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done      = done_r;
  assign remainder = neg_r ? -$signed(rem_r) : $signed(rem_r);

endmodule

[design/rpn_dp.sv]
module rpn_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rpn_pkg::dp_cmd_t                     cmd,
  output rpn_pkg::dp_stat_t                    stat,
  input  logic signed [rpn_pkg::NUM_W-1:0]     in_number,
  output logic [rpn_pkg::STATUS_W-1:0]         out_status,
  output logic signed [rpn_pkg::VALUE_W-1:0]   out_top_value,
  output logic                                 out_top_valid,
  output logic [rpn_pkg::DEPTH_W-1:0]          out_depth
);

  localparam int W = rpn_pkg::DATA_WIDTH;

  logic signed [W-1:0]              mem [rpn_pkg::STACK_DEPTH];
  logic [rpn_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic signed [W-1:0]              tos_r, tos_nxt;
  logic signed [W-1:0]              num_r;
  logic signed [W-1:0]              rd_r;
  logic signed [W-1:0]              res_r;
  logic [rpn_pkg::ADDR_W-1:0]       second_addr;
  logic                             wr_en;
  logic [rpn_pkg::ADDR_W-1:0]       wr_addr;
  logic signed [W-1:0]              wr_data;
  logic                             div_done;
  logic signed [W-1:0]              div_rem;
  logic [rpn_pkg::STATUS_W-1:0]     status_r;
  logic signed [rpn_pkg::VALUE_W-1:0] value_r;
  logic                             valid_r;
  logic [rpn_pkg::DEPTH_W-1:0]      depth_r;

  rpn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rd_r),
    .divisor   (tos_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign second_addr = rpn_pkg::ADDR_W'(count_r - rpn_pkg::CNT_W'(2));

  always_comb begin
    wr_en     = cmd.push || cmd.wb;
    wr_addr   = cmd.push ? count_r[rpn_pkg::ADDR_W-1:0] : second_addr;
    wr_data   = cmd.push ? num_r : res_r;
    count_nxt = count_r;
    tos_nxt   = tos_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
      tos_nxt   = num_r;
    end else if (cmd.wb) begin
      count_nxt = count_r - 1'b1;
      tos_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    tos_r <= tos_nxt;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_second) begin
      rd_r <= mem[second_addr];
    end
    if (cmd.latch_in) begin
      num_r <= W'(in_number);
    end
    if (cmd.alu_load) begin
      case (cmd.op)
        rpn_pkg::MODE_ADD: res_r <= rd_r + tos_r;
        rpn_pkg::MODE_SUB: res_r <= rd_r - tos_r;
        default:           res_r <= W'(rd_r * tos_r);
      endcase
    end else if (cmd.div_take) begin
      res_r <= div_rem;
    end
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      valid_r  <= (count_r != '0);
      value_r  <= (count_r != '0) ? rpn_pkg::VALUE_W'(tos_r) : '0;
      depth_r  <= rpn_pkg::DEPTH_W'(count_r);
    end
  end

  assign stat.lt_two   = (count_r < rpn_pkg::CNT_W'(2));
  assign stat.full     = (count_r == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
  assign stat.tos_zero = (tos_r == '0);
  assign stat.div_done = div_done;

  assign out_status    = status_r;
  assign out_top_value = value_r;
  assign out_top_valid = valid_r;
  assign out_depth     = depth_r;

endmodule

[design/rpn_ctrl.sv]
module rpn_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rpn_pkg::MODE_W-1:0]  in_mode,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output rpn_pkg::dp_cmd_t            cmd,
  input  rpn_pkg::dp_stat_t           stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [rpn_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [rpn_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         halted_r, halted_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    halted_nxt     = halted_r;
    cmd            = '0;
    cmd.op         = mode_r;
    cmd.out_status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          mode_nxt     = in_mode;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = rpn_pkg::ST_OK;
        state_nxt  = S_OUT;
        if (halted_r) begin
          status_nxt = rpn_pkg::ST_HALTED;
        end else begin
          case (mode_r) inside
            rpn_pkg::MODE_PUSH: begin
              if (stat.full) begin
                status_nxt = rpn_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
            rpn_pkg::MODE_MOD: begin
              if (stat.lt_two) begin
                status_nxt = rpn_pkg::ST_UNDERFLOW;
              end else if (mode_r == rpn_pkg::MODE_MOD && stat.tos_zero) begin
                status_nxt = rpn_pkg::ST_DIVZERO;
              end else begin
                cmd.rd_second = 1'b1;
                state_nxt     = S_READ;
              end
            end
            default: begin
              status_nxt = rpn_pkg::ST_UNKNOWN;
            end
          endcase
          if (status_nxt != rpn_pkg::ST_OK) begin
            halted_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        if (mode_r == rpn_pkg::MODE_MOD) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.alu_load = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r   <= mode_nxt;
    status_r <= status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

[design/rpn_stack_calculator_top.sv]
// Channel | Ports          | Contents
// in      | in_t*          | tuser: mode [2:0]; tdata: number [31:0]
// out     | out_t*         | tuser: status [2:0]; tdata: top_value, top_valid, depth
//
// One token is handled at a time. A push or an error goes from accept to the output
// register; add, subtract and multiply read the second operand, compute and write back,
// and modulo uses the one-bit-per-cycle remainder unit. A result waits in the output
// register while the next token is accepted; a stalled output holds the block before
// its next result is loaded. rst_n clears the stack count, the halt flag and all control.
module rpn_stack_calculator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rpn_pkg::NUM_W-1:0]           in_tdata,   // number [31:0]
  input  logic [rpn_pkg::MODE_W-1:0]          in_tuser,   // mode [2:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rpn_pkg::OUT_TDATA_W-1:0]     out_tdata,  // top_value [31:0], top_valid [32],
                                                          // depth [39:33]
  output logic [rpn_pkg::STATUS_W-1:0]        out_tuser   // status [2:0]
);

  rpn_pkg::dp_cmd_t                   cmd;
  rpn_pkg::dp_stat_t                  stat;
  logic signed [rpn_pkg::VALUE_W-1:0] top_value;
  logic                               top_valid;
  logic [rpn_pkg::DEPTH_W-1:0]        depth;

  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rpn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_number     ($signed(in_tdata)),
    .out_status    (out_tuser),
    .out_top_value (top_value),
    .out_top_valid (top_valid),
    .out_depth     (depth)
  );

  assign out_tdata = {depth, top_valid, top_value};

endmodule

[design/rpn_checker.sv]
module rpn_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rpn_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rpn_pkg::STATUS_W-1:0]    out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled result changed or was dropped.");

  a_valid_matches_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32] == (out_tdata[39:33] != '0))
    else $error("Top-valid flag disagrees with depth.");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == '0)
    else $error("Empty stack reported a nonzero top.");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] <= rpn_pkg::DEPTH_W'(rpn_pkg::STACK_DEPTH))
    else $error("Reported depth exceeds the stack size.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= rpn_pkg::ST_HALTED)
    else $error("Status code out of range.");

endmodule

bind rpn_stack_calculator_top rpn_checker u_rpn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
